// ===== hw/rtl/cfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the checksummed command framer.
// ----------------------------------------------------------------------------
package cfr_pkg;

	localparam logic [7:0]  SYNC_FIRST   = 8'h55;
	localparam logic [7:0]  SYNC_SECOND  = 8'hAA;
	localparam logic [15:0] ADDR_BYTES   = 16'd4;
	localparam logic [15:0] ADDR_MAX_PAY = 16'd65531;

	// input opcodes
	localparam logic OP_BEGIN   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// byte positions inside a header job
	localparam logic [3:0] POS_SYNC0  = 4'd0;
	localparam logic [3:0] POS_SYNC1  = 4'd1;
	localparam logic [3:0] POS_CMD    = 4'd2;
	localparam logic [3:0] POS_LEN_LO = 4'd3;
	localparam logic [3:0] POS_LEN_HI = 4'd4;
	localparam logic [3:0] POS_ADDR0  = 4'd5;
	localparam logic [3:0] POS_ADDR1  = 4'd6;
	localparam logic [3:0] POS_ADDR2  = 4'd7;
	localparam logic [3:0] POS_ADDR3  = 4'd8;

	localparam int QUEUE_DEPTH = 4;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic        hdr;    // 1 = header burst, 0 = single payload byte
		logic        wadr;   // header carries address bytes
		logic        close;  // checksum byte follows
		logic [7:0]  cmd;
		logic [15:0] sent;
		logic [31:0] addr;
		logic [7:0]  data;
		logic [7:0]  sum;
	} job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cfr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_front
// Accepts input items, tracks the open frame and its checksum, and turns
// each item that produces bytes into one job for the back end.
// ----------------------------------------------------------------------------
module cfr_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         opcode,
	input  wire logic [7:0]   frame_command,
	input  wire logic [15:0]  payload_length,
	input  wire logic         with_address,
	input  wire logic [31:0]  start_address,
	input  wire logic [7:0]   payload_byte,
	input  wire logic         q_full,
	output logic              push,
	output cfr_pkg::job_t     push_job
);

	logic        frame_open_q;
	logic [15:0] bytes_left_q;
	logic [7:0]  running_sum_q;

	logic        accept;
	logic        pay_ok;
	logic [15:0] plen_clip;
	logic [15:0] sent;
	logic [7:0]  hdr_sum;
	logic [7:0]  pay_sum;
	logic [15:0] left_next;
	logic        hdr_close;
	logic        pay_close;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pay_ok   = frame_open_q && (bytes_left_q != 16'd0);

	always_comb begin
		if (with_address && (payload_length > cfr_pkg::ADDR_MAX_PAY)) begin
			plen_clip = cfr_pkg::ADDR_MAX_PAY;
		end else begin
			plen_clip = payload_length;
		end
		sent = with_address ? (plen_clip + cfr_pkg::ADDR_BYTES) : plen_clip;
		hdr_sum = frame_command + sent[7:0] + sent[15:8];
		if (with_address) begin
			hdr_sum = hdr_sum + start_address[7:0] + start_address[15:8]
				+ start_address[23:16] + start_address[31:24];
		end
		hdr_close = (plen_clip == 16'd0);
		pay_sum   = running_sum_q + payload_byte;
		left_next = bytes_left_q - 16'd1;
		pay_close = (left_next == 16'd0);
	end

	always_comb begin
		push_job.hdr  = (opcode == cfr_pkg::OP_BEGIN);
		push_job.wadr = with_address;
		push_job.cmd  = frame_command;
		push_job.sent = sent;
		push_job.addr = start_address;
		push_job.data = payload_byte;
		if (opcode == cfr_pkg::OP_BEGIN) begin
			push_job.close = hdr_close;
			push_job.sum   = hdr_sum;
		end else begin
			push_job.close = pay_close;
			push_job.sum   = pay_sum;
		end
		push = accept && ((opcode == cfr_pkg::OP_BEGIN) || pay_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q  <= 1'b0;
			bytes_left_q  <= 16'd0;
			running_sum_q <= 8'd0;
		end else if (accept) begin
			if (opcode == cfr_pkg::OP_BEGIN) begin
				frame_open_q  <= !hdr_close;
				bytes_left_q  <= plen_clip;
				running_sum_q <= hdr_close ? 8'd0 : hdr_sum;
			end else if (pay_ok) begin
				frame_open_q  <= !pay_close;
				bytes_left_q  <= left_next;
				running_sum_q <= pay_close ? 8'd0 : pay_sum;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cfr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_queue
// Small job queue between the front and the back end.
// ----------------------------------------------------------------------------
module cfr_queue #(
	parameter int Depth = cfr_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cfr_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output cfr_pkg::job_t      head_job
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	cfr_pkg::job_t   slots_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntFull);
	assign head_valid = (count_q != '0);
	assign head_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cfr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_back
// Walks the head job one byte per cycle into the output reg, unless stalled.
// ----------------------------------------------------------------------------
module cfr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire cfr_pkg::job_t head_job,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               is_checksum,
	output logic               last_of_run
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       is_checksum_q;
	logic       last_of_run_q;

	logic [3:0] last_idx;
	logic       at_last;
	logic       load;
	logic [7:0] sel_byte;
	logic       sel_chk;

	always_comb begin
		if (head_job.hdr) begin
			last_idx = cfr_pkg::POS_LEN_HI;
			if (head_job.wadr) begin
				last_idx = cfr_pkg::POS_ADDR3;
			end
		end else begin
			last_idx = 4'd0;
		end
		if (head_job.close) begin
			last_idx = last_idx + 4'd1;
		end
		at_last = (idx_q == last_idx);
		load    = head_valid && (!out_valid_q || out_ready);
		pop     = load && at_last;
	end

	always_comb begin
		sel_chk = head_job.close && at_last;
		if (sel_chk) begin
			sel_byte = head_job.sum;
		end else if (!head_job.hdr) begin
			sel_byte = head_job.data;
		end else begin
			case (idx_q)
				cfr_pkg::POS_SYNC0:  sel_byte = cfr_pkg::SYNC_FIRST;
				cfr_pkg::POS_SYNC1:  sel_byte = cfr_pkg::SYNC_SECOND;
				cfr_pkg::POS_CMD:    sel_byte = head_job.cmd;
				cfr_pkg::POS_LEN_LO: sel_byte = head_job.sent[7:0];
				cfr_pkg::POS_LEN_HI: sel_byte = head_job.sent[15:8];
				cfr_pkg::POS_ADDR0:  sel_byte = head_job.addr[7:0];
				cfr_pkg::POS_ADDR1:  sel_byte = head_job.addr[15:8];
				cfr_pkg::POS_ADDR2:  sel_byte = head_job.addr[23:16];
				cfr_pkg::POS_ADDR3:  sel_byte = head_job.addr[31:24];
				default:             sel_byte = head_job.sum;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? 4'd0 : idx_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q    <= sel_byte;
			is_checksum_q <= sel_chk;
			last_of_run_q <= at_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign is_checksum = is_checksum_q;
	assign last_of_run = last_of_run_q;

endmodule
`default_nettype wire

// ===== hw/rtl/checksummed_command_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Takes one item per cycle while the job queue has room. A payload item inside
// an open frame yields one byte, or two when it closes the frame with its
// checksum; a begin item yields five to ten bytes (sync, command, length,
// optional address, checksum of an empty frame). The output side sends one
// byte per cycle from a single output register while out_ready allows, so a
// begin item holds the output until all of its bytes are out, and the front
// keeps accepting items until the QueueDepth-entry job queue fills. Payload
// outside a frame is taken and dropped without output.
// ----------------------------------------------------------------------------
// checksummed_command_framer
// Command frame builder with 8-bit additive checksum: front classifier,
// job queue and byte serializer.
// ----------------------------------------------------------------------------
module checksummed_command_framer #(
	parameter int QueueDepth = cfr_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         opcode,
	input  wire logic [7:0]   frame_command,
	input  wire logic [15:0]  payload_length,
	input  wire logic         with_address,
	input  wire logic [31:0]  start_address,
	input  wire logic [7:0]   payload_byte,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [7:0]        out_byte,
	output logic              is_checksum,
	output logic              last_of_run
);

	logic          q_full;
	logic          push;
	cfr_pkg::job_t push_job;
	logic          pop;
	logic          head_valid;
	cfr_pkg::job_t head_job;

	cfr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.frame_command  (frame_command),
		.payload_length (payload_length),
		.with_address   (with_address),
		.start_address  (start_address),
		.payload_byte   (payload_byte),
		.q_full         (q_full),
		.push           (push),
		.push_job       (push_job)
	);

	cfr_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	cfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.is_checksum (is_checksum),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire
